// ----- rtl/core/pyc_pkg.sv -----
// Shared constants for the pixel to YCoCg converter.
package pyc_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int PAL_W         = 24;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // pixel_format codes
  localparam logic [3:0] FMT_BGRX32 = 4'd0;
  localparam logic [3:0] FMT_BGRA32 = 4'd1;
  localparam logic [3:0] FMT_RGBX32 = 4'd2;
  localparam logic [3:0] FMT_RGBA32 = 4'd3;
  localparam logic [3:0] FMT_BGR24  = 4'd4;
  localparam logic [3:0] FMT_RGB24  = 4'd5;
  localparam logic [3:0] FMT_BGR16  = 4'd6;
  localparam logic [3:0] FMT_RGB16  = 4'd7;
  localparam logic [3:0] FMT_A4     = 4'd8;
  localparam logic [3:0] FMT_RGB8   = 4'd9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHROMA_SUBSAMPLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_LOSS_SHIFT = 2'd2;

  // input kinds
  localparam logic KIND_PIXEL   = 1'b0;
  localparam logic KIND_PALETTE = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

endpackage

// ----- rtl/core/pixel_to_ycocg_converter.sv -----
// out_tvalid rises once an accepted pixel request has moved from the stage 1 registers into the output register.
// Throughput: one request per cycle while out_tready is high; a padded row end holds
// the input while its padding result is offered from the output register.
// The palette RAM read sets the first stage; the color math the second.
// Reset (rst_n low, synchronous) restores register defaults, clears the column
// counter and pipeline valids; palette entries are undefined until written.
module pixel_to_ycocg_converter (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: byte_zero, byte_one, byte_two, byte_three, palette_index,
  //           palette_red, palette_green, palette_blue (low bits first)
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [pyc_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                             in_tuser,   // kind
  input  logic                             in_tlast,   // row_end
  // out_tdata: luma, chroma_orange, chroma_green, alpha (low bits first)
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pyc_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tuser,  // padding
  output logic                             out_tlast,  // last
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pyc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pyc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // configuration
  logic [3:0] pixel_format_r;
  logic       chroma_subsample_r;
  logic [2:0] color_loss_shift_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_format_r     <= pyc_pkg::FMT_BGRX32;
      chroma_subsample_r <= 1'b0;
      color_loss_shift_r <= 3'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pyc_pkg::REG_PIXEL_FORMAT:     pixel_format_r     <= cfg_data;
        pyc_pkg::REG_CHROMA_SUBSAMPLE: chroma_subsample_r <= cfg_data[0];
        pyc_pkg::REG_COLOR_LOSS_SHIFT: color_loss_shift_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [7:0] in_b0, in_b1, in_b2, in_b3, in_pal_idx;
  logic [pyc_pkg::PAL_W-1:0] in_pal_rgb;

  assign in_b0      = in_tdata[7:0];
  assign in_b1      = in_tdata[15:8];
  assign in_b2      = in_tdata[23:16];
  assign in_b3      = in_tdata[31:24];
  assign in_pal_idx = in_tdata[39:32];
  assign in_pal_rgb = {in_tdata[47:40], in_tdata[55:48], in_tdata[63:56]};

  // stage 0: accept, palette write or read, column tracking
  logic       in_acc, pix_acc, pal_wr;
  logic [2:0] column_count_r, column_count_nxt;
  logic [2:0] plane_bit;
  logic [3:0] plane_idx;
  logic [pyc_pkg::PAL_AW-1:0] rd_addr;
  logic       idx_out_of_range;
  logic       pad_req;
  logic [pyc_pkg::PAL_W-1:0] pal_rdata;

  assign in_acc  = in_tvalid && in_tready;
  assign pix_acc = in_acc && (in_tuser == pyc_pkg::KIND_PIXEL);
  assign pal_wr  = in_acc && (in_tuser == pyc_pkg::KIND_PALETTE) &&
                   ({1'b0, in_pal_idx} < 9'(pyc_pkg::PALETTE_DEPTH));

  // planar: bit 7 - column of each plane byte
  assign plane_bit = ~column_count_r;
  assign plane_idx = {in_b3[plane_bit], in_b2[plane_bit], in_b1[plane_bit], in_b0[plane_bit]};
  assign rd_addr   = (pixel_format_r == pyc_pkg::FMT_A4) ?
                     pyc_pkg::PAL_AW'(plane_idx) : in_b0[pyc_pkg::PAL_AW-1:0];
  assign idx_out_of_range = (pixel_format_r == pyc_pkg::FMT_RGB8) &&
                            ({1'b0, in_b0} >= 9'(pyc_pkg::PALETTE_DEPTH));

  // the row ends after an odd count when the count of pixels before this one is even
  assign pad_req = chroma_subsample_r && in_tlast && !column_count_r[0];

  always_comb begin
    column_count_nxt = column_count_r;
    if (pix_acc) begin
      column_count_nxt = in_tlast ? 3'd0 : column_count_r + 3'd1;
    end
  end

  pyc_ram #(
    .WIDTH(pyc_pkg::PAL_W),
    .DEPTH(pyc_pkg::PALETTE_DEPTH)
  ) u_palette (
    .clk    (clk),
    .wr_en  (pal_wr),
    .wr_addr(in_pal_idx[pyc_pkg::PAL_AW-1:0]),
    .wr_data(in_pal_rgb),
    .rd_en  (pix_acc),
    .rd_addr(rd_addr),
    .rd_data(pal_rdata)
  );

  // stage 1: unpack and convert
  logic        s1_valid_r, s1_valid_nxt;
  logic [31:0] s1_bytes_r;
  logic        s1_pad_r;
  logic        s1_zero_r;
  logic        s1_adv, out_free;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r, out_data_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_pad_r, out_pad_nxt;
  logic        pad_pend_r, pad_pend_nxt;

  assign out_free  = !out_valid_r || (out_tready && !pad_pend_r);
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tready) begin
      s1_valid_nxt = pix_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= 3'd0;
      s1_valid_r     <= 1'b0;
    end else begin
      column_count_r <= column_count_nxt;
      s1_valid_r     <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_bytes_r <= in_tdata[31:0];
      s1_pad_r   <= pad_req;
      s1_zero_r  <= idx_out_of_range;
    end
  end

  logic [7:0] b0, b1, b2, b3;
  logic [7:0] red, green, blue, alpha;
  logic [7:0] c565_hi, c565_lo, c565_g;
  logic [8:0] luma_sum;
  logic signed [8:0] co_full, co_sh;
  logic signed [9:0] cg_full, cg_sh;

  assign b0 = s1_bytes_r[7:0];
  assign b1 = s1_bytes_r[15:8];
  assign b2 = s1_bytes_r[23:16];
  assign b3 = s1_bytes_r[31:24];

  // 5-6-5; red and blue replicate their top bits into the low bits, green fills with zeros
  assign c565_hi = {b1[7:3], b1[7:5]};
  assign c565_lo = {b0[4:0], b0[4:2]};
  assign c565_g  = {b1[2:0], b0[7:5], 2'b00};

  always_comb begin
    red   = 8'd0;
    green = 8'd0;
    blue  = 8'd0;
    alpha = pyc_pkg::ALPHA_OPAQUE;
    case (pixel_format_r)
      pyc_pkg::FMT_BGRX32, pyc_pkg::FMT_BGR24: begin
        blue = b0; green = b1; red = b2;
      end
      pyc_pkg::FMT_BGRA32: begin
        blue = b0; green = b1; red = b2; alpha = b3;
      end
      pyc_pkg::FMT_RGBX32, pyc_pkg::FMT_RGB24: begin
        red = b0; green = b1; blue = b2;
      end
      pyc_pkg::FMT_RGBA32: begin
        red = b0; green = b1; blue = b2; alpha = b3;
      end
      pyc_pkg::FMT_BGR16: begin
        blue = c565_hi; green = c565_g; red = c565_lo;
      end
      pyc_pkg::FMT_RGB16: begin
        red = c565_hi; green = c565_g; blue = c565_lo;
      end
      pyc_pkg::FMT_A4, pyc_pkg::FMT_RGB8: begin
        if (!s1_zero_r) begin
          red   = pal_rdata[23:16];
          green = pal_rdata[15:8];
          blue  = pal_rdata[7:0];
        end
      end
      default: alpha = 8'd0;
    endcase
  end

  assign luma_sum = 9'(red >> 2) + 9'(green >> 1) + 9'(blue >> 2);
  assign co_full  = 9'(red) - 9'(blue);
  assign cg_full  = 10'(green) - 10'(red >> 1) - 10'(blue >> 1);
  assign co_sh    = co_full >>> color_loss_shift_r;
  assign cg_sh    = cg_full >>> color_loss_shift_r;

  // output register; a padding result reuses the held Y, Co, Cg with alpha 0
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_pad_nxt   = out_pad_r;
    pad_pend_nxt  = pad_pend_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {alpha, cg_sh[7:0], co_sh[7:0], luma_sum[7:0]};
      out_last_nxt  = !s1_pad_r;
      out_pad_nxt   = 1'b0;
      pad_pend_nxt  = s1_pad_r;
    end else if (out_valid_r && out_tready) begin
      if (pad_pend_r) begin
        out_data_nxt = {8'd0, out_data_r[23:0]};
        out_last_nxt = 1'b1;
        out_pad_nxt  = 1'b1;
        pad_pend_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pad_pend_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pad_pend_r  <= pad_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_pad_r  <= out_pad_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_pad_r;

endmodule

// ----- rtl/core/pyc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pyc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/pyc_checker.sv -----
// Port-level checks for the pixel to YCoCg converter, bound to the top level.
module pyc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [pyc_pkg::OUT_DATA_W-1:0]   out_tdata,
  input logic                             out_tuser,
  input logic                             out_tlast
);

  // synchronous reset empties the output
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // padding result is the final one and carries zero alpha
  a_pad_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata[31:24] == 8'd0))
    else $error("padding result malformed");

  // a non-final result is followed at once by its padding copy
  a_pad_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && out_tuser && (out_tdata[23:0] == $past(out_tdata[23:0])))
    else $error("padding result missing or not a copy");

endmodule

bind pixel_to_ycocg_converter pyc_checker u_pyc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);

// ----- verif/pixel_to_ycocg_converter_test.sv -----
// Self-checking testbench for the pixel to YCoCg converter: directed and random pixel streams.
`timescale 1ns / 1ps

module pixel_to_ycocg_converter_test;

  localparam int          CYCLE_LIMIT    = 200_000;
  localparam int          SETTLE_CYCLES  = 6;
  localparam int          PHASE_REQUESTS = 80;
  localparam logic [3:0]  FMT_UNKNOWN_LO = 4'd10;
  localparam logic [3:0]  FMT_UNKNOWN_HI = 4'd15;

  typedef struct packed {
    logic       kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic       row_end;
    logic [7:0] pal_index;
    logic [7:0] pal_red;
    logic [7:0] pal_green;
    logic [7:0] pal_blue;
  } pixel_req_t;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_orange;
    logic [7:0] chroma_green;
    logic [7:0] alpha;
    logic       padding;
    logic       last;
  } ycocg_result_t;

  // Tracks palette contents, column position and registers; queues expected YCoCg results.
  class ycocg_scoreboard;
    logic [pyc_pkg::PAL_W-1:0] palette [pyc_pkg::PALETTE_DEPTH];
    logic [2:0]       column;
    logic [3:0]       format;
    logic             subsample;
    logic [2:0]       loss_shift;
    ycocg_result_t    expected_pixels [$];
    int unsigned      errors;

    function new();
      column     = 3'd0;
      format     = pyc_pkg::FMT_BGRX32;
      subsample  = 1'b0;
      loss_shift = 3'd1;
      errors     = 0;
    endfunction

    function void set_reg(logic [pyc_pkg::CFG_IDX_W-1:0] idx,
                          logic [pyc_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        pyc_pkg::REG_PIXEL_FORMAT:     format = value;
        pyc_pkg::REG_CHROMA_SUBSAMPLE: subsample = value[0];
        pyc_pkg::REG_COLOR_LOSS_SHIFT: loss_shift = value[2:0];
        default: ;
      endcase
    endfunction

    function void palette_color(int idx, output logic [7:0] r, output logic [7:0] g,
                                output logic [7:0] b);
      logic [pyc_pkg::PAL_W-1:0] entry;
      entry = (idx < pyc_pkg::PALETTE_DEPTH) ? palette[idx] : '0;
      r = entry[23:16];
      g = entry[15:8];
      b = entry[7:0];
    endfunction

    function void note_request(pixel_req_t req);
      logic [7:0]    r, g, b, a, hi, lo;
      logic [2:0]    bitpos;
      logic [3:0]    pidx;
      int            ri, gi, bi, co, cg;
      logic          pad;
      ycocg_result_t res;
      if (req.kind == pyc_pkg::KIND_PALETTE) begin
        if (req.pal_index < pyc_pkg::PALETTE_DEPTH)
          palette[req.pal_index] = {req.pal_red, req.pal_green, req.pal_blue};
        return;
      end
      r = 8'd0;
      g = 8'd0;
      b = 8'd0;
      a = pyc_pkg::ALPHA_OPAQUE;
      case (format)
        pyc_pkg::FMT_BGRX32, pyc_pkg::FMT_BGR24: begin
          b = req.b0; g = req.b1; r = req.b2;
        end
        pyc_pkg::FMT_BGRA32: begin
          b = req.b0; g = req.b1; r = req.b2; a = req.b3;
        end
        pyc_pkg::FMT_RGBX32, pyc_pkg::FMT_RGB24: begin
          r = req.b0; g = req.b1; b = req.b2;
        end
        pyc_pkg::FMT_RGBA32: begin
          r = req.b0; g = req.b1; b = req.b2; a = req.b3;
        end
        pyc_pkg::FMT_BGR16, pyc_pkg::FMT_RGB16: begin
          // 5-6-5; red and blue replicate their top bits into the low bits, green fills with zeros
          hi = (req.b1 & 8'hF8) | (req.b1 >> 5);
          lo = ((req.b0 & 8'h1F) << 3) | ((req.b0 >> 2) & 8'h07);
          g  = ((req.b1 & 8'h07) << 5) | ((req.b0 & 8'hE0) >> 3);
          if (format == pyc_pkg::FMT_BGR16) begin
            b = hi; r = lo;
          end else begin
            r = hi; b = lo;
          end
        end
        pyc_pkg::FMT_A4: begin
          // planar: one bit per plane byte, MSB first along the row
          bitpos = 3'd7 - column;
          pidx = {req.b3[bitpos], req.b2[bitpos], req.b1[bitpos], req.b0[bitpos]};
          palette_color(pidx, r, g, b);
        end
        pyc_pkg::FMT_RGB8: palette_color(req.b0, r, g, b);
        default: a = 8'd0;
      endcase
      ri = r;
      gi = g;
      bi = b;
      co = (ri - bi) >>> loss_shift;
      cg = (gi - (ri >> 1) - (bi >> 1)) >>> loss_shift;
      res.luma          = (r >> 2) + (g >> 1) + (b >> 2);
      res.chroma_orange = co[7:0];
      res.chroma_green  = cg[7:0];
      res.alpha         = a;
      res.padding       = 1'b0;
      column = column + 3'd1;
      pad = 1'b0;
      if (req.row_end) begin
        pad = subsample && column[0];
        column = 3'd0;
      end
      res.last = !pad;
      expected_pixels.push_back(res);
      if (pad) begin
        res.alpha   = 8'd0;
        res.padding = 1'b1;
        res.last    = 1'b1;
        expected_pixels.push_back(res);
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%02h, actual 0x%02h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [pyc_pkg::OUT_DATA_W-1:0] data, logic pad, logic last);
      ycocg_result_t want;
      if (expected_pixels.size() == 0) begin
        $error("result with nothing expected: data 0x%08h padding %0b last %0b",
               data, pad, last);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      compare_field("luma", want.luma, data[7:0]);
      compare_field("chroma_orange", want.chroma_orange, data[15:8]);
      compare_field("chroma_green", want.chroma_green, data[23:16]);
      compare_field("alpha", want.alpha, data[31:24]);
      compare_field("padding", {7'd0, want.padding}, {7'd0, pad});
      compare_field("last", {7'd0, want.last}, {7'd0, last});
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [pyc_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                           in_tuser = 1'b0;
  logic                           in_tlast = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [pyc_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tuser;
  logic                           out_tlast;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [pyc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [pyc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  ycocg_scoreboard sb;
  bit              palette_loaded [pyc_pkg::PALETTE_DEPTH];
  int unsigned     sender_idle_pct = 0;
  int unsigned     receiver_stall_pct = 0;
  int unsigned     cycle_count = 0;

  pixel_to_ycocg_converter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pixel_to_ycocg_converter regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Inputs only move on rising edges, so the negedge sees what the next edge will take.
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata, out_tuser, out_tlast);
  end

  function automatic logic [7:0] random_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic pixel_req_t make_pixel(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                            logic [7:0] b3, logic row_end);
    pixel_req_t req;
    req = '0;
    req.kind = pyc_pkg::KIND_PIXEL;
    req.b0 = b0;
    req.b1 = b1;
    req.b2 = b2;
    req.b3 = b3;
    req.row_end = row_end;
    return req;
  endfunction

  function automatic pixel_req_t make_palette_write(logic [7:0] idx, logic [7:0] r,
                                                    logic [7:0] g, logic [7:0] b);
    pixel_req_t req;
    req = '0;
    req.kind = pyc_pkg::KIND_PALETTE;
    req.pal_index = idx;
    req.pal_red = r;
    req.pal_green = g;
    req.pal_blue = b;
    return req;
  endfunction

  function automatic pixel_req_t random_request(logic [3:0] fmt);
    pixel_req_t req;
    req.kind = ($urandom_range(9) == 0) ? pyc_pkg::KIND_PALETTE : pyc_pkg::KIND_PIXEL;
    req.b0 = random_byte();
    req.b1 = random_byte();
    req.b2 = random_byte();
    req.b3 = random_byte();
    req.row_end = ($urandom_range(4) == 0);
    req.pal_index = 8'($urandom_range(255));
    req.pal_red = random_byte();
    req.pal_green = random_byte();
    req.pal_blue = random_byte();
    // RGB8 palette index pixels only point at entries already loaded
    if (req.kind == pyc_pkg::KIND_PIXEL && fmt == pyc_pkg::FMT_RGB8)
      while (!palette_loaded[req.b0]) req.b0 = 8'($urandom_range(255));
    return req;
  endfunction

  // Returns just after the accepting edge with in_tvalid still high.
  task automatic send_request(pixel_req_t req);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req.kind;
    in_tlast  <= req.row_end;
    in_tdata  <= {req.pal_blue, req.pal_green, req.pal_red, req.pal_index,
                  req.b3, req.b2, req.b1, req.b0};
    do @(negedge clk); while (!in_tready);
    sb.note_request(req);
    if (req.kind == pyc_pkg::KIND_PALETTE) palette_loaded[req.pal_index] = 1'b1;
    @(posedge clk);
  endtask

  task automatic drain_results(int settle);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(logic [pyc_pkg::CFG_IDX_W-1:0] idx,
                           logic [pyc_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_ready);
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  // Palette writes leave no result, so allow the pipeline to empty before touching registers.
  task automatic configure(logic [3:0] fmt, logic subsample, logic [2:0] shift);
    drain_results(SETTLE_CYCLES);
    write_reg(pyc_pkg::REG_PIXEL_FORMAT, fmt);
    write_reg(pyc_pkg::REG_CHROMA_SUBSAMPLE, {3'b000, subsample});
    write_reg(pyc_pkg::REG_COLOR_LOSS_SHIFT, {1'b0, shift});
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [3:0] phase_formats [14];
    phase_formats = '{pyc_pkg::FMT_BGRX32, pyc_pkg::FMT_BGRA32, pyc_pkg::FMT_RGBX32,
                      pyc_pkg::FMT_RGBA32, pyc_pkg::FMT_BGR24, pyc_pkg::FMT_RGB24,
                      pyc_pkg::FMT_BGR16, pyc_pkg::FMT_RGB16, pyc_pkg::FMT_A4,
                      pyc_pkg::FMT_RGB8, FMT_UNKNOWN_LO, FMT_UNKNOWN_HI,
                      pyc_pkg::FMT_A4, pyc_pkg::FMT_RGB8};
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values: BGRX32, no subsampling, shift of one
    send_request(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    send_request(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
    send_request(make_pixel(8'h00, 8'h00, 8'hFF, 8'h00, 1'b0));
    send_request(make_pixel(8'hFF, 8'h00, 8'h00, 8'h00, 1'b0));
    send_request(make_pixel(8'h00, 8'hFF, 8'h00, 8'h5A, 1'b1));

    // odd rows get a padding result, even rows do not
    configure(pyc_pkg::FMT_BGRA32, 1'b1, 3'd0);
    send_request(make_pixel(8'h10, 8'h20, 8'h30, 8'h00, 1'b1));
    send_request(make_pixel(8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0));
    send_request(make_pixel(8'h00, 8'h00, 8'hFF, 8'h80, 1'b1));
    send_request(make_pixel(8'h01, 8'h02, 8'h03, 8'h04, 1'b0));
    send_request(make_pixel(8'hAA, 8'h55, 8'hAA, 8'h55, 1'b0));
    send_request(make_pixel(8'hFE, 8'h7F, 8'h01, 8'hFF, 1'b1));

    configure(pyc_pkg::FMT_RGB16, 1'b0, 3'd7);
    send_request(make_pixel(8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0));
    send_request(make_pixel(8'h00, 8'hF8, 8'h00, 8'h00, 1'b0));
    send_request(make_pixel(8'h1F, 8'h07, 8'h00, 8'h00, 1'b1));

    // palette entries at both ends of the index range
    configure(pyc_pkg::FMT_RGB8, 1'b0, 3'd1);
    send_request(make_palette_write(8'h00, 8'hFF, 8'h00, 8'hFF));
    send_request(make_palette_write(8'hFF, 8'h00, 8'hFF, 8'h00));
    send_request(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    send_request(make_pixel(8'hFF, 8'h00, 8'h00, 8'h00, 1'b1));

    configure(pyc_pkg::FMT_A4, 1'b0, 3'd1);
    send_request(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b1));

    // unknown format codes give zero color and zero alpha
    configure(FMT_UNKNOWN_LO, 1'b0, 3'd2);
    send_request(make_pixel(8'h12, 8'h34, 8'h56, 8'h78, 1'b0));
    configure(FMT_UNKNOWN_HI, 1'b1, 3'd2);
    send_request(make_pixel(8'h9A, 8'hBC, 8'hDE, 8'hF0, 1'b1));

    // all planar indices plus a spread of others before the random phases run
    for (int i = 0; i < 16; i++)
      send_request(make_palette_write(8'(i), random_byte(), random_byte(), random_byte()));
    for (int i = 0; i < 16; i++)
      send_request(make_palette_write(8'($urandom_range(255)), random_byte(), random_byte(),
                                      random_byte()));

    for (int phase = 0; phase < 14; phase++) begin
      configure(phase_formats[phase], phase[0], 3'(phase % 8));
      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 69; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 69; end
        default: begin sender_idle_pct = 15; receiver_stall_pct = 15; end
      endcase
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        if (n == PHASE_REQUESTS / 2) drain_results(0);
        send_request(random_request(phase_formats[phase]));
      end
    end

    drain_results(SETTLE_CYCLES);
    if (sb.errors == 0)
      $display("pixel_to_ycocg_converter regression: pass");
    else
      $display("pixel_to_ycocg_converter regression: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/pyc_pkg.sv
rtl/core/pyc_ram.sv
rtl/core/pixel_to_ycocg_converter.sv
rtl/core/pyc_checker.sv
verif/pixel_to_ycocg_converter_test.sv
